>>> rtl/mhpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DEF_CAPACITY  = 256;
    localparam int DEF_ID_COUNT  = 256;
    localparam int DEF_KEY_WIDTH = 32;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_DEC  = 2'd2;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_EMPTY     = 3'd1;
    localparam logic [2:0] STS_FULL      = 3'd2;
    localparam logic [2:0] STS_PRESENT   = 3'd3;
    localparam logic [2:0] STS_ABSENT    = 3'd4;
    localparam logic [2:0] STS_NOT_LOWER = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUSH_POS,
        ST_DEC_POS,
        ST_DEC_KEY,
        ST_UP_READ,
        ST_UP_CMP,
        ST_POP_ROOT,
        ST_POP_LAST,
        ST_DN_L,
        ST_DN_LCMP,
        ST_DN_RCMP,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

>>> rtl/mhpq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_req_if
// Operation channel: opcode, item id and key with valid/ready.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  item_id;
    logic [31:0] key;

    modport source (output valid, output opcode, output item_id, output key, input ready);
    modport sink   (input valid, input opcode, input item_id, input key, output ready);
endinterface
`default_nettype wire

>>> rtl/mhpq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_rsp_if
// Result channel: status, popped entry and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface mhpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        popped_valid;
    logic [7:0]  popped_id;
    logic [31:0] popped_key;
    logic [8:0]  entry_count;

    modport source (output valid, output status, output popped_valid, output popped_id,
                    output popped_key, output entry_count, input ready);
    modport sink   (input valid, input status, input popped_valid, input popped_id,
                    input popped_key, input entry_count, output ready);
endinterface
`default_nettype wire

>>> rtl/mhpq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/min_heap_priority_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top
// Binary min-heap of (key, id) entries with push, pop and decrease-key.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transaction: opcode (push, pop smallest,
//   decrease key), item_id and key. rsp returns exactly one result per
//   operation: status, the popped entry (pop only) and the entry count.
//   Flagged operations (empty, full, id present, id absent, key not lower)
//   leave the heap untouched.
// Operation flow:
//   One operation at a time. Push checks the id and then climbs from the new
//   leaf towards the root; decrease-key checks that the id is present and
//   that the key is lower, then climbs in the same way. Pop takes the root,
//   moves the last entry up to the root and sinks it, reading the left and
//   right child in turn, since they share the heap RAM read port.
// Reset:
//   After rst_n releases, a clearing pass writes every entry of the id
//   position RAM to zero; req.ready stays low meanwhile.
// Stall:
//   The result sits in an output register; the next operation is taken
//   while it waits, but its own result holds until rsp drains.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top
    import mhpq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int ID_COUNT  = DEF_ID_COUNT,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input wire logic   clk,
    input wire logic   rst_n,
    mhpq_req_if.sink   req,
    mhpq_rsp_if.source rsp
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(ID_COUNT);
    localparam int HW = KEY_WIDTH + IW;

    // heap RAM: slot = position - 1, word = {key, id}
    logic          heap_we;
    logic [AW-1:0] heap_waddr;
    logic [HW-1:0] heap_wdata;
    logic [AW-1:0] heap_raddr;
    logic [HW-1:0] heap_rdata;
    // position RAM: id -> heap position, zero when absent
    logic          pos_we;
    logic [IW-1:0] pos_waddr;
    logic [CW-1:0] pos_wdata;
    logic [IW-1:0] pos_raddr;
    logic [CW-1:0] pos_rdata;

    mhpq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    mhpq_ram #(.WIDTH(CW), .DEPTH(ID_COUNT)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    state_t state_reg, state_next;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [CW-1:0]        p_reg, p_next;
    logic [KEY_WIDTH-1:0] mov_key_reg, mov_key_next;
    logic [IW-1:0]        mov_id_reg, mov_id_next;
    logic [KEY_WIDTH-1:0] best_key_reg, best_key_next;
    logic [IW-1:0]        best_id_reg, best_id_next;
    logic                 best_left_reg, best_left_next;
    logic                 r_ok_reg, r_ok_next;
    logic [2:0]           sts_reg, sts_next;
    logic                 pv_reg, pv_next;
    logic [7:0]           pid_reg, pid_next;
    logic [31:0]          pkey_reg, pkey_next;
    logic [2:0]           o_sts_reg, o_sts_next;
    logic                 o_pv_reg, o_pv_next;
    logic [7:0]           o_pid_reg, o_pid_next;
    logic [31:0]          o_pkey_reg, o_pkey_next;
    logic [8:0]           o_cnt_reg, o_cnt_next;

    // shared decisions
    logic                 req_fire;
    logic                 id_ok;
    logic                 full;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [IW-1:0]        rd_id;
    logic [CW:0]          lpos;
    logic [CW:0]          rpos;
    logic                 l_in;
    logic                 r_in;
    logic                 up_more;
    logic                 up_move;
    logic                 dec_absent;
    logic                 dec_not_lower;
    logic                 lwin;
    logic                 rwin;
    logic                 out_load;

    assign req.ready     = (state_reg == ST_IDLE);
    assign req_fire      = req.valid && req.ready;
    assign id_ok         = (32'(req.item_id) < 32'(ID_COUNT));
    assign full          = (32'(count_reg) >= 32'(CAPACITY));
    assign rd_key        = heap_rdata[HW-1:IW];
    assign rd_id         = heap_rdata[IW-1:0];
    assign lpos          = {p_reg, 1'b0};
    assign rpos          = lpos + 1'b1;
    assign l_in          = (lpos <= {1'b0, count_reg});
    assign r_in          = (rpos <= {1'b0, count_reg});
    assign up_more       = (p_reg > CW'(1));
    assign up_move       = (rd_key > mov_key_reg);
    assign dec_absent    = (pos_rdata == '0) || (pos_rdata > count_reg);
    assign dec_not_lower = (mov_key_reg >= rd_key);
    assign lwin          = (rd_key < mov_key_reg);
    assign rwin          = r_ok_reg && (rd_key < best_key_reg);
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == IW'(ID_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.opcode)
                        OP_PUSH: state_next = (full || !id_ok) ? ST_DONE : ST_PUSH_POS;
                        OP_POP:  state_next = (count_reg == '0) ? ST_DONE : ST_POP_ROOT;
                        OP_DEC:  state_next = id_ok ? ST_DEC_POS : ST_DONE;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_PUSH_POS: state_next = (pos_rdata != '0) ? ST_DONE : ST_UP_READ;
            ST_DEC_POS:  state_next = dec_absent ? ST_DONE : ST_DEC_KEY;
            ST_DEC_KEY:  state_next = dec_not_lower ? ST_DONE : ST_UP_READ;
            ST_UP_READ:  state_next = up_more ? ST_UP_CMP : ST_DONE;
            ST_UP_CMP:   state_next = up_move ? ST_UP_READ : ST_DONE;
            ST_POP_ROOT: state_next = (count_reg == CW'(1)) ? ST_DONE : ST_POP_LAST;
            ST_POP_LAST: state_next = ST_DN_L;
            ST_DN_L:     state_next = l_in ? ST_DN_LCMP : ST_DONE;
            ST_DN_LCMP:  state_next = ST_DN_RCMP;
            ST_DN_RCMP:  state_next = (rwin || best_left_reg) ? ST_DN_L : ST_DONE;
            ST_DONE:     state_next = out_load ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        heap_we        = 1'b0;
        heap_waddr     = AW'(p_reg - 1'b1);
        heap_wdata     = {mov_key_reg, mov_id_reg};
        heap_raddr     = '0;
        pos_we         = 1'b0;
        pos_waddr      = mov_id_reg;
        pos_wdata      = p_reg;
        pos_raddr      = IW'(req.item_id);
        clr_idx_next   = clr_idx_reg;
        count_next     = count_reg;
        p_next         = p_reg;
        mov_key_next   = mov_key_reg;
        mov_id_next    = mov_id_reg;
        best_key_next  = best_key_reg;
        best_id_next   = best_id_reg;
        best_left_next = best_left_reg;
        r_ok_next      = r_ok_reg;
        sts_next       = sts_reg;
        pv_next        = pv_reg;
        pid_next       = pid_reg;
        pkey_next      = pkey_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                pos_we       = 1'b1;
                pos_waddr    = clr_idx_reg;
                pos_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    sts_next     = STS_OK;
                    pv_next      = 1'b0;
                    pid_next     = '0;
                    pkey_next    = '0;
                    mov_key_next = KEY_WIDTH'(req.key);
                    mov_id_next  = IW'(req.item_id);
                    case (req.opcode)
                        OP_PUSH:
                        begin
                            if (full)
                            begin
                                sts_next = STS_FULL;
                            end
                            else if (!id_ok)
                            begin
                                sts_next = STS_ABSENT;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                sts_next = STS_EMPTY;
                            end
                        end
                        OP_DEC:
                        begin
                            if (!id_ok)
                            begin
                                sts_next = STS_ABSENT;
                            end
                        end
                        default: sts_next = STS_OK;
                    endcase
                end
            end
            ST_PUSH_POS:
            begin
                if (pos_rdata != '0)
                begin
                    sts_next = STS_PRESENT;
                end
                else
                begin
                    count_next = CW'(count_reg + 1'b1);
                    p_next     = CW'(count_reg + 1'b1);
                end
            end
            ST_DEC_POS:
            begin
                heap_raddr = AW'(pos_rdata - 1'b1);
                p_next     = pos_rdata;
                if (dec_absent)
                begin
                    sts_next = STS_ABSENT;
                end
            end
            ST_DEC_KEY:
            begin
                if (dec_not_lower)
                begin
                    sts_next = STS_NOT_LOWER;
                end
            end
            ST_UP_READ:
            begin
                heap_raddr = AW'((p_reg >> 1) - 1'b1);
                if (!up_more)
                begin
                    // reached the root: drop the moving entry here
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                end
            end
            ST_UP_CMP:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (up_move)
                begin
                    // pull the larger parent down into the hole
                    heap_wdata = heap_rdata;
                    pos_waddr  = rd_id;
                    p_next     = p_reg >> 1;
                end
            end
            ST_POP_ROOT:
            begin
                pv_next    = 1'b1;
                pid_next   = 8'(rd_id);
                pkey_next  = 32'(rd_key);
                pos_we     = 1'b1;
                pos_waddr  = rd_id;
                pos_wdata  = '0;
                count_next = count_reg - 1'b1;
                heap_raddr = AW'(count_reg - 1'b1);
            end
            ST_POP_LAST:
            begin
                mov_key_next = rd_key;
                mov_id_next  = rd_id;
                p_next       = CW'(1);
            end
            ST_DN_L:
            begin
                heap_raddr = AW'(lpos - 1'b1);
                if (!l_in)
                begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                end
            end
            ST_DN_LCMP:
            begin
                heap_raddr     = AW'(lpos);
                r_ok_next      = r_in;
                best_left_next = lwin;
                best_key_next  = lwin ? rd_key : mov_key_reg;
                best_id_next   = lwin ? rd_id : mov_id_reg;
            end
            ST_DN_RCMP:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (rwin)
                begin
                    heap_wdata = heap_rdata;
                    pos_waddr  = rd_id;
                    p_next     = CW'(rpos);
                end
                else if (best_left_reg)
                begin
                    heap_wdata = {best_key_reg, best_id_reg};
                    pos_waddr  = best_id_reg;
                    p_next     = CW'(lpos);
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        o_sts_next     = o_sts_reg;
        o_pv_next      = o_pv_reg;
        o_pid_next     = o_pid_reg;
        o_pkey_next    = o_pkey_reg;
        o_cnt_next     = o_cnt_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            o_sts_next     = sts_reg;
            o_pv_next      = pv_reg;
            o_pid_next     = pid_reg;
            o_pkey_next    = pkey_reg;
            o_cnt_next     = 9'(count_reg);
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        mov_key_reg   <= mov_key_next;
        mov_id_reg    <= mov_id_next;
        best_key_reg  <= best_key_next;
        best_id_reg   <= best_id_next;
        best_left_reg <= best_left_next;
        r_ok_reg      <= r_ok_next;
        sts_reg       <= sts_next;
        pv_reg        <= pv_next;
        pid_reg       <= pid_next;
        pkey_reg      <= pkey_next;
        o_sts_reg     <= o_sts_next;
        o_pv_reg      <= o_pv_next;
        o_pid_reg     <= o_pid_next;
        o_pkey_reg    <= o_pkey_next;
        o_cnt_reg     <= o_cnt_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = o_sts_reg;
    assign rsp.popped_valid = o_pv_reg;
    assign rsp.popped_id    = o_pid_reg;
    assign rsp.popped_key   = o_pkey_reg;
    assign rsp.entry_count  = o_cnt_reg;

    // the heap never holds more entries than it has slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CAPACITY))
        else $error("entry count beyond capacity");

    // no transaction is taken during the clearing pass
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request accepted during clear");

    // a popped entry only comes with a good status
    a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_pv_reg) |-> (o_sts_reg == STS_OK))
        else $error("popped entry with flagged status");

    // a result is loaded only once the previous one has drained
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> $stable(o_cnt_reg) && out_valid_reg)
        else $error("pending result overwritten");
endmodule
`default_nettype wire
